@@ rtl/char_lcd_4bit_interface_defines.svh @@
// Assertion macros shared by the LCD interface RTL.
// No dependencies; included by the modules that carry checks.
`ifndef CHAR_LCD_4BIT_INTERFACE_DEFINES_SVH
`define CHAR_LCD_4BIT_INTERFACE_DEFINES_SVH
`ifndef SYNTH
`define CLCD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("clcd assertion failed");
`define CLCD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("clcd forbidden condition seen");
`else
`define CLCD_ASSERT(lbl, clk, rst_n, prop)
`define CLCD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/clcd_pkg.sv @@
// Shared types, codes and constants for the 4-bit character LCD interface.
// No dependencies.
package clcd_pkg;

	localparam int MaxOps = 5;
	localparam int CntW   = $clog2(MaxOps + 1);

	typedef enum logic [1:0] {
		ReqInit      = 2'd0,
		ReqPutChar   = 2'd1,
		ReqGoto      = 2'd2,
		ReqBusyReply = 2'd3
	} req_t;

	typedef enum logic {
		KindWrite    = 1'b0,
		KindBusyRead = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		WaitShort = 2'd0,
		Wait100us = 2'd1,
		Wait5ms   = 2'd2,
		Wait15ms  = 2'd3
	} wcls_t;

	typedef struct packed {
		kind_t       kind;
		logic        rs;
		logic [3:0]  nib;
		wcls_t       wcls;
	} op_t;

	// one request's worth of bus operations, entry 0 goes out first
	typedef struct packed {
		op_t [MaxOps-1:0] ops;
		logic [CntW-1:0]  cnt;
	} burst_t;

	localparam logic [7:0] CharFormFeed = 8'h0C;
	localparam logic [7:0] CharNewline  = 8'h0A;
	localparam logic [7:0] CharPrintLo  = 8'h20;
	localparam logic [7:0] CharPrintHi  = 8'h7E;
	localparam logic [7:0] CmdClear     = 8'h01;
	localparam logic [7:0] CmdRow1Home  = 8'hC0;
	localparam logic [7:0] CmdSetDdram  = 8'h80;
	localparam logic [7:0] Row1Base     = 8'h40;
	localparam logic [3:0] NibInit3     = 4'h3;
	localparam logic [3:0] NibInit2     = 4'h2;
	localparam logic [2:0] InitFirst    = 3'd1;
	localparam logic [2:0] InitLast     = 3'd5;

	// power-up command sequence, indexed from 0
	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h28;
			3'd1:    c = 8'h08;
			3'd2:    c = 8'h01;
			3'd3:    c = 8'h06;
			3'd4:    c = 8'h0E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/clcd_decode.sv @@
// Request decoder and controller state: turns one request into its bus operations.
// Depends on clcd_pkg and the assertion macro header.
`include "char_lcd_4bit_interface_defines.svh"

module clcd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  clcd_pkg::req_t      req_type,
	input  logic [7:0]          char_code,
	input  logic [5:0]          column,
	input  logic                row,
	input  logic                busy_req,
	output clcd_pkg::burst_t    burst
);

	logic        waiting_q, waiting_d;
	logic [7:0]  pend_byte_q, pend_byte_d;
	logic        pend_rs_q, pend_rs_d;
	logic [2:0]  init_step_q, init_step_d;

	clcd_pkg::op_t busy_op;
	logic [7:0]    addr;

	always_comb begin
		busy_op      = '0;
		busy_op.kind = clcd_pkg::KindBusyRead;
		addr         = (row ? clcd_pkg::Row1Base : 8'h00) + {2'b00, column};
	end

	always_comb begin
		burst       = '0;
		waiting_d   = waiting_q;
		pend_byte_d = pend_byte_q;
		pend_rs_d   = pend_rs_q;
		init_step_d = init_step_q;
		case (req_type)
			clcd_pkg::ReqInit: begin
				burst.ops[0] = '{clcd_pkg::KindWrite, 1'b0, clcd_pkg::NibInit3,
					clcd_pkg::Wait15ms};
				burst.ops[1] = '{clcd_pkg::KindWrite, 1'b0, clcd_pkg::NibInit3,
					clcd_pkg::Wait100us};
				burst.ops[2] = '{clcd_pkg::KindWrite, 1'b0, clcd_pkg::NibInit3,
					clcd_pkg::WaitShort};
				burst.ops[3] = '{clcd_pkg::KindWrite, 1'b0, clcd_pkg::NibInit2,
					clcd_pkg::WaitShort};
				burst.ops[4] = busy_op;
				burst.cnt    = clcd_pkg::CntW'(5);
				init_step_d  = clcd_pkg::InitFirst;
				pend_byte_d  = clcd_pkg::init_cmd(3'd0);
				pend_rs_d    = 1'b0;
				waiting_d    = 1'b1;
			end
			clcd_pkg::ReqPutChar: begin
				if (!waiting_q) begin
					if (char_code == clcd_pkg::CharFormFeed) begin
						burst.ops[0] = busy_op;
						burst.cnt    = clcd_pkg::CntW'(1);
						pend_byte_d  = clcd_pkg::CmdClear;
						pend_rs_d    = 1'b0;
						waiting_d    = 1'b1;
					end else if (char_code == clcd_pkg::CharNewline) begin
						burst.ops[0] = busy_op;
						burst.cnt    = clcd_pkg::CntW'(1);
						pend_byte_d  = clcd_pkg::CmdRow1Home;
						pend_rs_d    = 1'b0;
						waiting_d    = 1'b1;
					end else if (char_code inside
						{[clcd_pkg::CharPrintLo:clcd_pkg::CharPrintHi]}) begin
						burst.ops[0] = busy_op;
						burst.cnt    = clcd_pkg::CntW'(1);
						pend_byte_d  = char_code;
						pend_rs_d    = 1'b1;
						waiting_d    = 1'b1;
					end
				end
			end
			clcd_pkg::ReqGoto: begin
				if (!waiting_q) begin
					burst.ops[0] = busy_op;
					burst.cnt    = clcd_pkg::CntW'(1);
					pend_byte_d  = clcd_pkg::CmdSetDdram | addr;
					pend_rs_d    = 1'b0;
					waiting_d    = 1'b1;
				end
			end
			clcd_pkg::ReqBusyReply: begin
				if (waiting_q) begin
					if (busy_req) begin
						burst.ops[0] = busy_op;
						burst.cnt    = clcd_pkg::CntW'(1);
					end else begin
						burst.ops[0] = '{clcd_pkg::KindWrite, pend_rs_q, pend_byte_q[7:4],
							clcd_pkg::WaitShort};
						burst.ops[1] = '{clcd_pkg::KindWrite, pend_rs_q, pend_byte_q[3:0],
							clcd_pkg::WaitShort};
						waiting_d    = 1'b0;
						// mid-sequence: queue the next power-up command
						if (init_step_q != 3'd0 && init_step_q != clcd_pkg::InitLast) begin
							burst.ops[2] = busy_op;
							burst.cnt    = clcd_pkg::CntW'(3);
							pend_byte_d  = clcd_pkg::init_cmd(init_step_q);
							pend_rs_d    = 1'b0;
							init_step_d  = init_step_q + 3'd1;
							waiting_d    = 1'b1;
						end else begin
							burst.cnt    = clcd_pkg::CntW'(2);
							init_step_d  = 3'd0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q   <= 1'b0;
			pend_byte_q <= 8'h00;
			pend_rs_q   <= 1'b0;
			init_step_q <= 3'd0;
		end else if (accept) begin
			waiting_q   <= waiting_d;
			pend_byte_q <= pend_byte_d;
			pend_rs_q   <= pend_rs_d;
			init_step_q <= init_step_d;
		end
	end

	`CLCD_NEVER(a_step_range, clk, arst_n, init_step_q > clcd_pkg::InitLast)
	`CLCD_ASSERT(a_init_waits, clk, arst_n, (init_step_q != 3'd0) |-> waiting_q)
	`CLCD_ASSERT(a_init_start, clk, arst_n,
		(accept && req_type == clcd_pkg::ReqInit) |=>
		(init_step_q == clcd_pkg::InitFirst && waiting_q))

endmodule

@@ rtl/clcd_burst.sv @@
// Operation buffer and output register: hands out one bus operation per word.
// Depends on clcd_pkg and the assertion macro header.
`include "char_lcd_4bit_interface_defines.svh"

module clcd_burst (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  clcd_pkg::burst_t     burst,
	output logic                 out_valid,
	input  logic                 out_ready,
	output clcd_pkg::op_t        out_op,
	output logic                 out_last
);

	clcd_pkg::op_t [clcd_pkg::MaxOps-1:0] ops_q;
	logic [clcd_pkg::CntW-1:0]            cnt_q;
	logic                                 out_valid_q;
	clcd_pkg::op_t                        out_op_q;
	logic                                 out_last_q;
	logic                                 take;
	logic                                 load;

	assign take     = (cnt_q != '0) && (!out_valid_q || out_ready);
	// free once the final queued word moves to the output register
	assign in_ready = (cnt_q == '0) || (cnt_q == clcd_pkg::CntW'(1) && take);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				cnt_q <= burst.cnt;
			else if (take)
				cnt_q <= cnt_q - clcd_pkg::CntW'(1);
			if (take)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ops_q <= burst.ops;
		else if (take)
			ops_q <= {clcd_pkg::op_t'('0), ops_q[clcd_pkg::MaxOps-1:1]};
		if (take) begin
			out_op_q   <= ops_q[0];
			out_last_q <= (cnt_q == clcd_pkg::CntW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_op    = out_op_q;
	assign out_last  = out_last_q;

	`CLCD_NEVER(a_cnt_range, clk, arst_n, cnt_q > clcd_pkg::CntW'(clcd_pkg::MaxOps))
	`CLCD_ASSERT(a_take_valid, clk, arst_n, take |=> out_valid_q)
	`CLCD_ASSERT(a_last_mark, clk, arst_n,
		take |=> (out_last_q == ($past(cnt_q) == clcd_pkg::CntW'(1))))

endmodule

@@ rtl/char_lcd_4bit_interface.sv @@
// Top level of the 4-bit character LCD interface.
// Depends on clcd_pkg, clcd_decode and clcd_burst.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  request | in_valid / in_ready  | req_type char_code column row busy_req
//  bus op  | out_valid / out_ready| op_kind register_select nibble wait_class last
//
// A request is decoded in the cycle it is accepted into a list of up to five bus ops.
// Ops leave one per cycle while out_ready allows, through an output register; the first op
// is loaded into the op buffer on acceptance and then moves to the output register.
// The next request is taken in the cycle its predecessor's final op moves to the output
// register. Requests that produce no op are accepted and load nothing into the buffer.
// Reset clears control state.
// A stalled out_ready holds one op in the output register and backs up the buffer.

module char_lcd_4bit_interface (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [5:0]  column,
	input  logic        row,
	input  logic        busy_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        op_kind,
	output logic        register_select,
	output logic [3:0]  nibble,
	output logic [1:0]  wait_class,
	output logic        last
);

	clcd_pkg::burst_t burst;
	clcd_pkg::op_t    op;
	logic             accept;

	assign accept = in_valid && in_ready;

	clcd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (clcd_pkg::req_t'(req_type)),
		.char_code (char_code),
		.column    (column),
		.row       (row),
		.busy_req  (busy_req),
		.burst     (burst)
	);

	clcd_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.burst     (burst),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_op    (op),
		.out_last  (last)
	);

	assign op_kind         = op.kind;
	assign register_select = op.rs;
	assign nibble          = op.nib;
	assign wait_class      = op.wcls;

endmodule
